>>> sv/system_bus_decode_and_io_glue_macros.svh
// Assertion macros for the system bus decode and I/O glue checker.
`ifndef SYSTEM_BUS_DECODE_AND_IO_GLUE_MACROS_SVH
`define SYSTEM_BUS_DECODE_AND_IO_GLUE_MACROS_SVH

// Checked outside reset.
`define SBDIO_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sbdio check failed");

// Checked in every cycle, reset included.
`define SBDIO_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("sbdio check failed");

`endif

>>> sv/sbdio_pkg.sv
// Package: word types, command/region codes and address map of the bus glue.
`timescale 1ns / 1ps

package sbdio_pkg;

   localparam int RAM_BYTES = 262144;

   localparam logic [23:0] RAM_BASE = 24'h400000;
   localparam logic [24:0] RAM_END  = 25'(32'h400000 + RAM_BYTES);

   localparam logic [2:0] CMD_READ  = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_TICK  = 3'd2;
   localparam logic [2:0] CMD_KEY   = 3'd3;
   localparam logic [2:0] CMD_RX    = 3'd4;

   localparam logic [2:0] REGION_NONE  = 3'd0;
   localparam logic [2:0] REGION_ROM   = 3'd1;
   localparam logic [2:0] REGION_SRAM  = 3'd2;
   localparam logic [2:0] REGION_SPELL = 3'd3;
   localparam logic [2:0] REGION_RAM   = 3'd4;

   localparam logic [1:0] CSR_DIP    = 2'd0;
   localparam logic [1:0] CSR_XLATE  = 2'd1;
   localparam logic [1:0] CSR_WD_LIM = 2'd2;

   localparam logic [23:0] ROM_MASK        = 24'hE40000;
   localparam logic [23:0] SRAM_MASK       = 24'hE70001;
   localparam logic [23:0] SRAM_MATCH      = 24'h040000;
   localparam logic [23:0] SPELL_MASK      = 24'hE40001;
   localparam logic [23:0] SPELL_MATCH     = 24'h200001;
   localparam logic [23:0] VRAM_END        = 24'h4070E0;
   localparam logic [23:0] ADDR_KBD        = 24'h80000A;
   localparam logic [23:0] ADDR_UART_STATA = 24'h810003;
   localparam logic [23:0] ADDR_UART_DATA  = 24'h810007;
   localparam logic [23:0] ADDR_UART_PORT  = 24'h810009;
   localparam logic [23:0] ADDR_UART_INT   = 24'h81000B;
   localparam logic [23:0] ADDR_PRN_STAT   = 24'h81001B;
   localparam logic [23:0] ADDR_HIGH_IO    = 24'h870000;
   localparam logic [23:0] ADDR_DISP       = 24'h840001;
   localparam logic [23:0] ADDR_PRN_CTL    = 24'h80000E;
   localparam logic [23:0] ADDR_ROW_SEL    = 24'h800002;
   localparam logic [23:0] ADDR_PRN_DATA   = 24'h800004;

   localparam logic [7:0] PRN_CTL_DIP   = 8'h09;
   localparam logic [7:0] PRN_READY     = 8'h10;
   localparam logic [7:0] STATA_KEEP    = 8'h04;
   localparam logic [7:0] INT_KEEP      = 8'h3B;
   localparam logic [7:0] INT_TIMER     = 8'h80;
   localparam logic [7:0] INT_RX        = 8'h02;
   localparam logic [7:0] STATA_RXFULL  = 8'h01;
   localparam logic [7:0] PORT_TICK     = 8'h40;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;

   typedef enum logic [3:0] {
      SEL_NONE      = 4'd0,
      SEL_KBD       = 4'd1,
      SEL_STATA     = 4'd2,
      SEL_RXBUF     = 4'd3,
      SEL_PORT_CHG  = 4'd4,
      SEL_INT_STAT  = 4'd5,
      SEL_PRN_STAT  = 4'd6,
      SEL_HIGH      = 4'd7,
      SEL_DISP      = 4'd8,
      SEL_PRN_CTL   = 4'd9,
      SEL_ROW_SEL   = 4'd10,
      SEL_PRN_BYTE  = 4'd11,
      SEL_SER_BYTE  = 4'd12
   } reg_sel_type;

   typedef struct packed {
      logic [2:0]  region;
      logic [21:0] offset;
      reg_sel_type reg_sel;
      logic        vram;
   } dec_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [23:0] address;
      logic [7:0]  data_byte;
      logic [2:0]  key_row;
      logic [2:0]  key_column;
      logic        key_released;
   } req_type;

   typedef struct packed {
      logic [2:0]  mem_region;
      logic [21:0] mem_offset;
      logic [7:0]  read_data;
      logic        irq_request;
      logic        watchdog_expired;
      logic        display_blank;
      logic        display_invert;
      logic        vram_hit;
      logic        printer_valid;
      logic        serial_tx_valid;
      logic [7:0]  out_byte;
      logic        rx_accepted;
   } rsp_type;

endpackage

>>> sv/sbdio_decode.sv
// Address decoder: memory region, offset and I/O register select of a bus access.
`timescale 1ns / 1ps

module sbdio_decode (
   input  logic [2:0]        command,
   input  logic [23:0]       address,
   output sbdio_pkg::dec_type dec
);
   import sbdio_pkg::*;

   logic ram_hit;
   logic sram_hit;

   assign ram_hit  = ({1'b0, address} >= {1'b0, RAM_BASE}) && ({1'b0, address} < RAM_END);
   assign sram_hit = (address & SRAM_MASK) == SRAM_MATCH;

   always_comb begin
      dec         = '0;
      dec.region  = REGION_NONE;
      dec.reg_sel = SEL_NONE;
      unique case (command)
         CMD_READ: begin
            if ((address & ROM_MASK) == 24'h0) begin
               dec.region = REGION_ROM;
               dec.offset = {4'b0, address[17:0]};
            end else if (sram_hit) begin
               dec.region = REGION_SRAM;
               dec.offset = {9'b0, address[13:1]};
            end else if ((address & SPELL_MASK) == SPELL_MATCH) begin
               dec.region = REGION_SPELL;
               dec.offset = {5'b0, address[17:1]};
            end else if (address[23:22] == 2'b00) begin
               dec.region = REGION_NONE;
            end else if (ram_hit) begin
               dec.region = REGION_RAM;
               dec.offset = address[21:0];
            end else if (address[23:22] == 2'b01) begin
               dec.region = REGION_NONE;
            end else if (address == ADDR_KBD) begin
               dec.reg_sel = SEL_KBD;
            end else if (address == ADDR_UART_STATA) begin
               dec.reg_sel = SEL_STATA;
            end else if (address == ADDR_UART_DATA) begin
               dec.reg_sel = SEL_RXBUF;
            end else if (address == ADDR_UART_PORT) begin
               dec.reg_sel = SEL_PORT_CHG;
            end else if (address == ADDR_UART_INT) begin
               dec.reg_sel = SEL_INT_STAT;
            end else if (address == ADDR_PRN_STAT) begin
               dec.reg_sel = SEL_PRN_STAT;
            end else if (address >= ADDR_HIGH_IO) begin
               dec.reg_sel = SEL_HIGH;
            end
         end
         CMD_WRITE: begin
            if (ram_hit) begin
               dec.region = REGION_RAM;
               dec.offset = address[21:0];
               dec.vram   = address < VRAM_END;
            end else if (sram_hit) begin
               dec.region = REGION_SRAM;
               dec.offset = {9'b0, address[13:1]};
            end else if (address == ADDR_DISP) begin
               dec.reg_sel = SEL_DISP;
            end else if (address == ADDR_PRN_CTL) begin
               dec.reg_sel = SEL_PRN_CTL;
            end else if (address == ADDR_ROW_SEL) begin
               dec.reg_sel = SEL_ROW_SEL;
            end else if (address == ADDR_PRN_DATA) begin
               dec.reg_sel = SEL_PRN_BYTE;
            end else if (address == ADDR_UART_DATA) begin
               dec.reg_sel = SEL_SER_BYTE;
            end
         end
         default: begin
            dec.reg_sel = SEL_NONE;
         end
      endcase
   end

endmodule

>>> sv/system_bus_decode_and_io_glue.sv
// Top level of the system bus decode and I/O glue.
`timescale 1ns / 1ps
//
// Usage:
//   req_* carries one command word (bus read, bus write, timer tick, key
//   change, serial receive) per valid/ready handshake; rsp_* returns exactly
//   one result word per command, in order.
//   csr_* writes the DIP switch byte, newline translation and watchdog limit;
//   write only while no command is in flight.
// Pipeline: an accepted request goes through the input register, then
//   decode and register update into the result register behind rsp_valid.
// Throughput: one word per cycle while rsp_ready holds; a command's register
//   side effects (clear on read, watchdog, key matrix) settle as it advances.
// Reset: all I/O registers return to their power-up values;
//   both pipeline stages empty.
// Stall: a held result keeps rsp_data steady; one more command may wait in
//   the input register, after which req_ready drops until rsp_ready returns.
//
module system_bus_decode_and_io_glue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sbdio_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sbdio_pkg::rsp_type  rsp_data,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);
   import sbdio_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       advance;
   logic       req_accept;

   logic [7:0] dip_ff, dip_in;
   logic       xlate_ff, xlate_in;
   logic [6:0] wd_limit_ff, wd_limit_in;

   logic [7:0] key_matrix_ff [8];
   logic [7:0] key_matrix_in [8];
   logic [7:0] row_select_ff, row_select_in;
   logic [7:0] prn_ctl_ff, prn_ctl_in;
   logic [7:0] int_stat_ff, int_stat_in;
   logic [7:0] stat_a_ff, stat_a_in;
   logic [7:0] rx_buf_ff, rx_buf_in;
   logic [7:0] port_chg_ff, port_chg_in;
   logic [6:0] wd_count_ff, wd_count_in;
   logic       parity_ff, parity_in;
   logic       blank_ff, blank_in;
   logic       invert_ff, invert_in;

   dec_type    dec;
   logic [7:0] kbd_value;

   sbdio_decode u_decode (
      .command (s1_data_ff.command),
      .address (s1_data_ff.address),
      .dec     (dec)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dip_in      = (csr_write && csr_index == CSR_DIP) ? csr_data : dip_ff;
   assign xlate_in    = (csr_write && csr_index == CSR_XLATE) ? csr_data[0] : xlate_ff;
   assign wd_limit_in = (csr_write && csr_index == CSR_WD_LIM) ? csr_data[6:0] : wd_limit_ff;

   always_comb begin
      kbd_value = 8'hFF;
      if (prn_ctl_ff == PRN_CTL_DIP) begin
         kbd_value = dip_ff;
      end else begin
         for (int r = 0; r < 8; r++) begin
            if (row_select_ff == 8'(1 << r)) begin
               kbd_value = key_matrix_ff[r];
            end
         end
      end
   end

   always_comb begin
      key_matrix_in = key_matrix_ff;
      row_select_in = row_select_ff;
      prn_ctl_in    = prn_ctl_ff;
      int_stat_in   = int_stat_ff;
      stat_a_in     = stat_a_ff;
      rx_buf_in     = rx_buf_ff;
      port_chg_in   = port_chg_ff;
      wd_count_in   = wd_count_ff;
      parity_in     = parity_ff;
      blank_in      = blank_ff;
      invert_in     = invert_ff;
      rsp_data_in            = '0;
      rsp_data_in.mem_region = dec.region;
      rsp_data_in.mem_offset = dec.offset;
      rsp_data_in.vram_hit   = dec.vram;

      if (advance) begin
         case (dec.reg_sel)
            SEL_KBD:      rsp_data_in.read_data = kbd_value;
            SEL_STATA: begin
               rsp_data_in.read_data = stat_a_ff;
               stat_a_in = stat_a_ff & STATA_KEEP;
            end
            SEL_RXBUF:    rsp_data_in.read_data = rx_buf_ff;
            SEL_PORT_CHG: begin
               rsp_data_in.read_data = port_chg_ff;
               port_chg_in = 8'h00;
            end
            SEL_INT_STAT: begin
               rsp_data_in.read_data = int_stat_ff;
               int_stat_in = int_stat_ff & INT_KEEP;
            end
            SEL_PRN_STAT: rsp_data_in.read_data = PRN_READY;
            SEL_HIGH:     rsp_data_in.read_data = 8'hFF;
            SEL_DISP: begin
               if (!s1_data_ff.data_byte[2]) begin
                  blank_in = 1'b1;
               end else begin
                  blank_in  = 1'b0;
                  invert_in = s1_data_ff.data_byte[4];
               end
               if (s1_data_ff.data_byte[3]) begin
                  wd_count_in = 7'd0;
               end
            end
            SEL_PRN_CTL:  prn_ctl_in = s1_data_ff.data_byte;
            SEL_ROW_SEL:  row_select_in = s1_data_ff.data_byte;
            SEL_PRN_BYTE: begin
               rsp_data_in.printer_valid = 1'b1;
               rsp_data_in.out_byte      = s1_data_ff.data_byte;
            end
            SEL_SER_BYTE: begin
               rsp_data_in.serial_tx_valid = 1'b1;
               rsp_data_in.out_byte = (xlate_ff && s1_data_ff.data_byte == CHAR_CR) ?
                                      CHAR_LF : s1_data_ff.data_byte;
            end
            default: ;
         endcase

         case (s1_data_ff.command)
            CMD_TICK: begin
               if (wd_count_ff != 7'h7F) begin
                  wd_count_in = wd_count_ff + 7'd1;
               end
               parity_in   = ~parity_ff;
               int_stat_in = int_stat_ff | INT_TIMER;
               port_chg_in = PORT_TICK | {5'b0, ~parity_ff, 2'b0};
               rsp_data_in.irq_request = 1'b1;
            end
            CMD_KEY: begin
               key_matrix_in[s1_data_ff.key_row][s1_data_ff.key_column] =
                  s1_data_ff.key_released;
            end
            CMD_RX: begin
               if (!stat_a_ff[0]) begin
                  rx_buf_in = (xlate_ff && s1_data_ff.data_byte == CHAR_LF) ?
                              CHAR_CR : s1_data_ff.data_byte;
                  stat_a_in   = stat_a_ff | STATA_RXFULL;
                  int_stat_in = int_stat_ff | INT_RX;
                  rsp_data_in.rx_accepted = 1'b1;
               end
            end
            default: ;
         endcase
      end

      rsp_data_in.watchdog_expired = wd_count_in > wd_limit_ff;
      rsp_data_in.display_blank    = blank_in;
      rsp_data_in.display_invert   = invert_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dip_ff        <= 8'hFF;
         xlate_ff      <= 1'b0;
         wd_limit_ff   <= 7'd64;
         for (int r = 0; r < 8; r++) begin
            key_matrix_ff[r] <= 8'hFF;
         end
         row_select_ff <= 8'h00;
         prn_ctl_ff    <= 8'h00;
         int_stat_ff   <= 8'h19;
         stat_a_ff     <= 8'h04;
         rx_buf_ff     <= 8'h00;
         port_chg_ff   <= 8'h00;
         wd_count_ff   <= 7'd0;
         parity_ff     <= 1'b0;
         blank_ff      <= 1'b0;
         invert_ff     <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         dip_ff        <= dip_in;
         xlate_ff      <= xlate_in;
         wd_limit_ff   <= wd_limit_in;
         key_matrix_ff <= key_matrix_in;
         row_select_ff <= row_select_in;
         prn_ctl_ff    <= prn_ctl_in;
         int_stat_ff   <= int_stat_in;
         stat_a_ff     <= stat_a_in;
         rx_buf_ff     <= rx_buf_in;
         port_chg_ff   <= port_chg_in;
         wd_count_ff   <= wd_count_in;
         parity_ff     <= parity_in;
         blank_ff      <= blank_in;
         invert_ff     <= invert_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> sv/sbdio_checker.sv
// Port-level checker for the bus glue, bound to the top level.
`timescale 1ns / 1ps
`include "system_bus_decode_and_io_glue_macros.svh"

module sbdio_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input sbdio_pkg::rsp_type rsp_data
);
   import sbdio_pkg::*;

   `SBDIO_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

   `SBDIO_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   `SBDIO_ASSERT(a_one_port, rsp_valid |-> !(rsp_data.printer_valid && rsp_data.serial_tx_valid))

   `SBDIO_ASSERT(a_no_region_offset, rsp_valid && rsp_data.mem_region == REGION_NONE |-> rsp_data.mem_offset == 22'd0)

   `SBDIO_ASSERT(a_irq_no_bus, rsp_valid && rsp_data.irq_request |-> rsp_data.mem_region == REGION_NONE && rsp_data.read_data == 8'd0)

endmodule

bind system_bus_decode_and_io_glue sbdio_checker u_sbdio_checker (.*);

>>> bench/tb.sv
// Self-checking testbench for the bus decode and I/O glue: mirrored I/O state, random words.
`timescale 1ns / 1ps

import sbdio_pkg::*;

class io_mirror;
   logic [7:0] dip;
   logic       xlate;
   logic [6:0] wd_limit;
   logic [7:0] keys [8];
   logic [7:0] row_select;
   logic [7:0] prn_ctl;
   logic [7:0] int_stat;
   logic [7:0] stat_a;
   logic [7:0] rx_buf;
   logic [7:0] port_chg;
   logic [6:0] wd_count;
   logic       parity;
   logic       blank;
   logic       invert;
   rsp_type    pending [$];
   int unsigned failures;

   function new();
      dip = 8'hFF;
      xlate = 1'b0;
      wd_limit = 7'd64;
      foreach (keys[k]) keys[k] = 8'hFF;
      row_select = '0;
      prn_ctl = '0;
      int_stat = 8'h19;
      stat_a = STATA_KEEP;
      rx_buf = '0;
      port_chg = '0;
      wd_count = '0;
      parity = 1'b0;
      blank = 1'b0;
      invert = 1'b0;
      failures = 0;
   endfunction

   function int unsigned waiting();
      return pending.size();
   endfunction

   function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
         CSR_DIP: dip = val;
         CSR_XLATE: xlate = val[0];
         CSR_WD_LIM: wd_limit = val[6:0];
         default: ;
      endcase
   endfunction

   function void note_command(req_type w);
      rsp_type    r;
      logic [23:0] a;
      logic [7:0]  d;
      logic [7:0]  v;
      logic        ram;
      int          k;
      r = '0;
      a = w.address;
      d = w.data_byte;
      ram = (25'(a) >= 25'(RAM_BASE)) && (25'(a) < RAM_END);
      case (w.command)
         CMD_READ: begin
            if ((a & ROM_MASK) == '0) begin
               r.mem_region = REGION_ROM;
               r.mem_offset = 22'(a[17:0]);
            end else if ((a & SRAM_MASK) == SRAM_MATCH) begin
               r.mem_region = REGION_SRAM;
               r.mem_offset = 22'(a[13:1]);
            end else if ((a & SPELL_MASK) == SPELL_MATCH) begin
               r.mem_region = REGION_SPELL;
               r.mem_offset = 22'(a[17:1]);
            end else if (a[23:22] == 2'b00) begin
            end else if (ram) begin
               r.mem_region = REGION_RAM;
               r.mem_offset = 22'(a - RAM_BASE);
            end else if (a[23:22] == 2'b01) begin
            end else if (a == ADDR_KBD) begin
               v = 8'hFF;
               if (prn_ctl == PRN_CTL_DIP) v = dip;
               else for (k = 0; k < 8; k++) if (row_select == 8'(1 << k)) v = keys[k];
               r.read_data = v;
            end else if (a == ADDR_UART_STATA) begin
               r.read_data = stat_a;
               stat_a &= STATA_KEEP;
            end else if (a == ADDR_UART_DATA) begin
               r.read_data = rx_buf;
            end else if (a == ADDR_UART_PORT) begin
               r.read_data = port_chg;
               port_chg = '0;
            end else if (a == ADDR_UART_INT) begin
               r.read_data = int_stat;
               int_stat &= INT_KEEP;
            end else if (a == ADDR_PRN_STAT) begin
               r.read_data = PRN_READY;
            end else if (a >= ADDR_HIGH_IO) begin
               r.read_data = 8'hFF;
            end
         end
         CMD_WRITE: begin
            if (ram) begin
               r.mem_region = REGION_RAM;
               r.mem_offset = 22'(a - RAM_BASE);
               r.vram_hit = (a < VRAM_END);
            end else if ((a & SRAM_MASK) == SRAM_MATCH) begin
               r.mem_region = REGION_SRAM;
               r.mem_offset = 22'(a[13:1]);
            end else if (a == ADDR_DISP) begin
               if (!d[2]) blank = 1'b1;
               else begin
                  blank = 1'b0;
                  invert = d[4];
               end
               if (d[3]) wd_count = '0;
            end else if (a == ADDR_PRN_CTL) begin
               prn_ctl = d;
            end else if (a == ADDR_ROW_SEL) begin
               row_select = d;
            end else if (a == ADDR_PRN_DATA) begin
               r.printer_valid = 1'b1;
               r.out_byte = d;
            end else if (a == ADDR_UART_DATA) begin
               r.serial_tx_valid = 1'b1;
               r.out_byte = (xlate && d == CHAR_CR) ? CHAR_LF : d;
            end
         end
         CMD_TICK: begin
            if (wd_count != '1) wd_count++;
            parity = ~parity;
            int_stat |= INT_TIMER;
            port_chg = PORT_TICK | {5'b0, parity, 2'b0};
            r.irq_request = 1'b1;
         end
         CMD_KEY: begin
            if (w.key_released) keys[w.key_row] |= 8'(1 << w.key_column);
            else keys[w.key_row] &= ~8'(1 << w.key_column);
         end
         CMD_RX: begin
            if (!stat_a[0]) begin
               rx_buf = (xlate && d == CHAR_LF) ? CHAR_CR : d;
               stat_a |= STATA_RXFULL;
               int_stat |= INT_RX;
               r.rx_accepted = 1'b1;
            end
         end
         default: ;
      endcase
      r.watchdog_expired = (wd_count > wd_limit);
      r.display_blank = blank;
      r.display_invert = invert;
      pending.push_back(r);
   endfunction

   function void compare(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
         failures++;
         $display("%0t: %s expected %0h got %0h", $time, name, e, g);
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type e;
      if (pending.size() == 0) begin
         failures++;
         $display("%0t: result word %h with none expected", $time, got);
         return;
      end
      e = pending.pop_front();
      compare("mem_region", 32'(e.mem_region), 32'(got.mem_region));
      compare("mem_offset", 32'(e.mem_offset), 32'(got.mem_offset));
      compare("read_data", 32'(e.read_data), 32'(got.read_data));
      compare("irq_request", 32'(e.irq_request), 32'(got.irq_request));
      compare("watchdog_expired", 32'(e.watchdog_expired), 32'(got.watchdog_expired));
      compare("display_blank", 32'(e.display_blank), 32'(got.display_blank));
      compare("display_invert", 32'(e.display_invert), 32'(got.display_invert));
      compare("vram_hit", 32'(e.vram_hit), 32'(got.vram_hit));
      compare("printer_valid", 32'(e.printer_valid), 32'(got.printer_valid));
      compare("serial_tx_valid", 32'(e.serial_tx_valid), 32'(got.serial_tx_valid));
      compare("out_byte", 32'(e.out_byte), 32'(got.out_byte));
      compare("rx_accepted", 32'(e.rx_accepted), 32'(got.rx_accepted));
   endfunction
endclass

module tb;
   localparam int WATCHDOG_LIMIT = 1000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;
   logic       calm = 1'b0;
   int         idle_cycles = 0;
   io_mirror   book;

   system_bus_decode_and_io_glue DUT (.*);

   always #1 clock = ~clock;

   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_word(logic [2:0] cmd, logic [23:0] addr, logic [7:0] data);
      req_type w;
      w = '0;
      w.command = cmd;
      w.address = addr;
      w.data_byte = data;
      return w;
   endfunction

   // cases 0..5 are the readable I/O registers
   function automatic logic [23:0] pick_addr(int hi);
      case ($urandom_range(0, hi))
         0: return ADDR_KBD;
         1: return ADDR_UART_STATA;
         2: return ADDR_UART_DATA;
         3: return ADDR_UART_PORT;
         4: return ADDR_UART_INT;
         5: return ADDR_PRN_STAT;
         6: return ADDR_DISP;
         7: return ADDR_PRN_CTL;
         8: return ADDR_ROW_SEL;
         9: return ADDR_PRN_DATA;
         10: return 24'($urandom_range(32'h870000, 32'hFFFFFF));
         11: return RAM_BASE + 24'($urandom_range(0, RAM_BYTES - 1));
         12: return VRAM_END - 24'd2 + 24'($urandom_range(0, 3));
         13: return SRAM_MATCH | (24'($urandom) & 24'h18FFFE);
         14: return SPELL_MATCH | (24'($urandom) & 24'h1BFFFE);
         15: return 24'($urandom) & 24'h1BFFFF;
         16: return 24'(RAM_END - 25'd1 + 25'($urandom_range(0, 1)));
         17: return 24'h810000 | 24'($urandom_range(0, 31));
         18: return 24'h800000 | 24'($urandom_range(0, 15));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_type rand_word();
      req_type w;
      int      r;
      w.address = 24'($urandom);
      w.data_byte = 8'($urandom);
      w.key_row = 3'($urandom);
      w.key_column = 3'($urandom);
      w.key_released = 1'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) begin
         w.command = CMD_READ;
         w.address = pick_addr(($urandom_range(0, 9) < 4) ? 5 : 19);
      end else if (r < 60) begin
         w.command = CMD_WRITE;
         w.address = pick_addr(19);
         if (w.address == ADDR_ROW_SEL && $urandom_range(0, 3) != 0)
            w.data_byte = 8'(1 << $urandom_range(0, 7));
         if (w.address == ADDR_PRN_CTL && $urandom_range(0, 9) < 4)
            w.data_byte = PRN_CTL_DIP;
         if (w.address == ADDR_UART_DATA && $urandom_range(0, 1))
            w.data_byte = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
      end else if (r < 72) begin
         w.command = CMD_TICK;
      end else if (r < 84) begin
         w.command = CMD_KEY;
      end else if (r < 96) begin
         w.command = CMD_RX;
         if ($urandom_range(0, 9) < 3) w.data_byte = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
      end else begin
         w.command = 3'($urandom_range(5, 7));
      end
      return w;
   endfunction

   task automatic send_word(req_type w);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      book.note_command(w);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (book.waiting() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      book.set_reg(idx, val);
   endtask

   task automatic set_config(logic [7:0] dip, logic xlate, logic [6:0] lim);
      stop_sending();
      drain();
      write_reg(CSR_DIP, dip);
      write_reg(CSR_XLATE, {7'b0, xlate});
      write_reg(CSR_WD_LIM, {1'b0, lim});
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         calm = (i < n / 5);
         send_word(rand_word());
      end
      calm = 1'b0;
   endtask

   task automatic tick_burst(int n);
      req_type w;
      for (int i = 0; i < n; i++) begin
         w = rand_word();
         w.command = CMD_TICK;
         send_word(w);
      end
   endtask

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) book.check_result(rsp_data);
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type plan [$];
      req_type w;
      book = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      plan.push_back(make_word(CMD_READ, 24'h1BFFFF, 8'h00));
      plan.push_back(make_word(CMD_READ, 24'h1CFFFE, 8'h00));
      plan.push_back(make_word(CMD_READ, 24'h3BFFFF, 8'h00));
      plan.push_back(make_word(CMD_READ, RAM_BASE, 8'h00));
      plan.push_back(make_word(CMD_READ, 24'(RAM_END - 25'd1), 8'h00));
      plan.push_back(make_word(CMD_READ, 24'(RAM_END), 8'h00));
      plan.push_back(make_word(CMD_READ, 24'hFFFFFF, 8'h00));
      plan.push_back(make_word(CMD_WRITE, ADDR_ROW_SEL, 8'h01));
      w = make_word(CMD_KEY, '0, '0);
      w.key_column = 3'd7;
      plan.push_back(w);
      plan.push_back(make_word(CMD_READ, ADDR_KBD, 8'h00));
      plan.push_back(make_word(CMD_WRITE, ADDR_ROW_SEL, 8'h03));
      plan.push_back(make_word(CMD_READ, ADDR_KBD, 8'h00));
      plan.push_back(make_word(CMD_WRITE, ADDR_PRN_CTL, PRN_CTL_DIP));
      plan.push_back(make_word(CMD_READ, ADDR_KBD, 8'h00));
      plan.push_back(make_word(CMD_RX, '0, CHAR_LF));
      plan.push_back(make_word(CMD_RX, '0, 8'h55));
      plan.push_back(make_word(CMD_READ, ADDR_UART_DATA, 8'h00));
      plan.push_back(make_word(CMD_READ, ADDR_UART_STATA, 8'h00));
      plan.push_back(make_word(CMD_READ, ADDR_UART_INT, 8'h00));
      plan.push_back(make_word(CMD_TICK, '0, 8'h00));
      plan.push_back(make_word(CMD_READ, ADDR_UART_PORT, 8'h00));
      plan.push_back(make_word(CMD_WRITE, ADDR_DISP, 8'h00));
      plan.push_back(make_word(CMD_WRITE, ADDR_DISP, 8'h1C));
      plan.push_back(make_word(CMD_WRITE, ADDR_PRN_DATA, 8'hFF));
      plan.push_back(make_word(CMD_WRITE, ADDR_UART_DATA, CHAR_CR));
      plan.push_back(make_word(CMD_WRITE, VRAM_END - 24'd1, 8'hA5));
      w = '1;
      plan.push_back(w);
      plan.push_back(make_word(CMD_READ, ADDR_PRN_STAT, 8'h00));
      foreach (plan[i]) send_word(plan[i]);

      set_config(8'h00, 1'b1, 7'd1);
      run_random(350);

      set_config(8'hA5, 1'b0, 7'd126);
      tick_burst(135);
      run_random(150);
      // let everything drain before carrying on
      stop_sending();
      drain();
      run_random(150);

      set_config(8'hFF, 1'b1, 7'd0);
      run_random(300);

      set_config(8'($urandom), 1'b0, 7'd127);
      tick_burst(135);
      run_random(250);

      stop_sending();
      drain();
      if (book.failures == 0 && book.waiting() == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule
